// File: rtl/aesbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesbe_pkg
// Shared types, register indexes and AES tables for the block encrypt unit.
// ----------------------------------------------------------------------------
package aesbe_pkg;

  localparam int unsigned NUM_ROUNDS = 10;

  // Configuration register indexes.
  localparam logic [1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW  = 2'd1;
  localparam logic [1:0] REG_IV_HIGH  = 2'd2;
  localparam logic [1:0] REG_IV_LOW   = 2'd3;

  // One pipeline beat: the cipher state and the round key that goes with it.
  // Byte 0 sits in bits [127:120].
  typedef struct packed {
    logic [127:0] state;
    logic [127:0] rkey;
  } cell_data_t;

  localparam logic [7:0] RCON [NUM_ROUNDS] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] sbox(input logic [7:0] b);
    return SBOX[b];
  endfunction

  // Multiply by x in GF(2^8) with the AES polynomial.
  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

// File: rtl/aes128_block_encrypt_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_block_encrypt_unit
// AES-128 encryption of blocks XORed with a fixed IV, as a chain of round
// cells that each hold one block in flight.
// ----------------------------------------------------------------------------
//  Channel   Direction  Width  Contents
//  s_axis    in         128    plain_high [63:0], plain_low [127:64]
//  m_axis    out        128    cipher_high [63:0], cipher_low [127:64]
//  cfg       in         64     key_high, key_low, iv_high, iv_low by index
//
//  One block is accepted every cycle while the output is not stalled. There are
//  eleven registers in the path, the whitening register and one per round cell,
//  and a result is presented on m_axis once it has passed through all of them.
//  Each cell has its own valid bit, so a stalled output only holds back the
//  cells that are full; bubbles further up keep filling.
//  Reset clears all valid bits and sets key and IV to zero.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // plain_high [63:0], plain_low [127:64]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // cipher_high [63:0], cipher_low [127:64]
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_addr,
  input  logic [63:0]  cfg_wdata
);
  import aesbe_pkg::*;

  logic [63:0] key_high;
  logic [63:0] key_low;
  logic [63:0] iv_high;
  logic [63:0] iv_low;

  logic       stage_valid [NUM_ROUNDS + 1];
  logic       stage_ready [NUM_ROUNDS + 1];
  cell_data_t stage_data  [NUM_ROUNDS + 1];

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      iv_high  <= '0;
      iv_low   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_KEY_HIGH: key_high <= cfg_wdata;
        REG_KEY_LOW:  key_low  <= cfg_wdata;
        REG_IV_HIGH:  iv_high  <= cfg_wdata;
        REG_IV_LOW:   iv_low   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Whitening stage: IV and the initial round key go in together.
  assign s_axis_tready = !stage_valid[0] || stage_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid[0] <= 1'b0;
    end else if (s_axis_tready) begin
      stage_valid[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      stage_data[0].state <= {s_axis_tdata[63:0], s_axis_tdata[127:64]}
                             ^ {iv_high, iv_low} ^ {key_high, key_low};
      stage_data[0].rkey  <= {key_high, key_low};
    end
  end

  for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
    aesbe_round_cell #(
      .ROUND(r)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (stage_valid[r]),
      .in_ready (stage_ready[r]),
      .in_data  (stage_data[r]),
      .out_valid(stage_valid[r + 1]),
      .out_ready(stage_ready[r + 1]),
      .out_data (stage_data[r + 1])
    );
  end

  assign stage_ready[NUM_ROUNDS] = m_axis_tready;
  assign m_axis_tvalid = stage_valid[NUM_ROUNDS];
  assign m_axis_tdata  = {stage_data[NUM_ROUNDS].state[63:0],
                          stage_data[NUM_ROUNDS].state[127:64]};

endmodule

// File: rtl/aesbe_round_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesbe_round_cell
// One AES round with its own key expansion step, registered at the output.
// ----------------------------------------------------------------------------
module aesbe_round_cell #(
  parameter int unsigned ROUND = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  aesbe_pkg::cell_data_t in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output aesbe_pkg::cell_data_t out_data
);
  import aesbe_pkg::*;

  localparam bit LAST_ROUND = (ROUND == NUM_ROUNDS - 1);

  logic [7:0]  s     [16];
  logic [7:0]  k     [16];
  logic [7:0]  nk    [16];
  logic [7:0]  t     [16];
  logic [7:0]  m     [16];
  logic [7:0]  kt    [4];
  cell_data_t  data_next;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = in_data.state[127 - 8*i -: 8];
      k[i] = in_data.rkey[127 - 8*i -: 8];
    end

    // Key schedule: rotate, substitute and add the round constant.
    kt[0] = sbox(k[13]) ^ RCON[ROUND];
    kt[1] = sbox(k[14]);
    kt[2] = sbox(k[15]);
    kt[3] = sbox(k[12]);
    for (int i = 0; i < 4; i++) begin
      nk[i]      = k[i] ^ kt[i];
      nk[i + 4]  = k[i + 4] ^ nk[i];
      nk[i + 8]  = k[i + 8] ^ nk[i + 4];
      nk[i + 12] = k[i + 12] ^ nk[i + 8];
    end

    // SubBytes and ShiftRows; byte i sits at row i mod 4, column i / 4.
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[4*c + r] = sbox(s[4*((c + r) % 4) + r]);
      end
    end

    for (int c = 0; c < 4; c++) begin
      if (LAST_ROUND) begin
        for (int r = 0; r < 4; r++) begin
          m[4*c + r] = t[4*c + r];
        end
      end else begin
        for (int r = 0; r < 4; r++) begin
          m[4*c + r] = t[4*c + r] ^ t[4*c] ^ t[4*c + 1] ^ t[4*c + 2] ^ t[4*c + 3]
                       ^ xtime(t[4*c + r] ^ t[4*c + ((r + 1) % 4)]);
        end
      end
    end

    for (int i = 0; i < 16; i++) begin
      data_next.state[127 - 8*i -: 8] = m[i] ^ nk[i];
      data_next.rkey[127 - 8*i -: 8]  = nk[i];
    end
  end

  // The cell takes a beat whenever its own register is free or is drained.
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule
